/* hdl/tbhmc_pkg.sv */
// Shared types and constants for the two-button hold and mode controller.
// Used by tbhmc_cfg_regs, tbhmc_step and the core top level; no dependencies.
`default_nettype none

package tbhmc_pkg;

  // Number of illumination modes; the mode index wraps at this count.
  localparam int NUM_ILLUM_MODES = 8;
  localparam logic [8:0] ILLUM_MODE_COUNT = 9'(NUM_ILLUM_MODES);

  // Command codes of an input item.
  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_POWER_EDGE = 2'd1;
  localparam logic [1:0] CMD_MODE_EDGE  = 2'd2;

  // Device state codes.
  localparam logic [1:0] DEV_SLEEP = 2'd0;
  localparam logic [1:0] DEV_WORK  = 2'd1;
  localparam logic [1:0] DEV_CALIB = 2'd2;

  // Register indexes on the configuration port (word address).
  localparam logic [1:0] REG_ADC_SHIFT    = 2'd0;
  localparam logic [1:0] REG_COMBO_HOLD   = 2'd1;
  localparam logic [1:0] REG_SINGLE_HOLD  = 2'd2;

  localparam int LEVEL_W = 12;
  localparam int HOLD_W  = 16;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        power_pin_high;
    logic        mode_pin_high;
    logic [11:0] adc_red;
    logic [11:0] adc_green;
    logic [11:0] adc_blue;
    logic [11:0] adc_bright;
  } item_t;

  typedef struct packed {
    logic [1:0]  device_state;
    logic [7:0]  illum_mode;
    logic        power_armed;
    logic        mode_armed;
    logic [11:0] level_red;
    logic [11:0] level_green;
    logic [11:0] level_blue;
    logic [11:0] level_bright;
  } result_t;

  typedef struct packed {
    logic [3:0] adc_shift;
    logic [7:0] combo_hold_ticks;
    logic [7:0] single_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              dev_state;
    logic [7:0]              illum_mode;
    logic [HOLD_W-1:0]       power_hold;
    logic [HOLD_W-1:0]       mode_hold;
    logic                    power_latch;
    logic                    mode_latch;
    logic [3:0][LEVEL_W-1:0] levels;
  } ctrl_state_t;

endpackage

`default_nettype wire

/* hdl/tbhmc_cfg_regs.sv */
// APB-style configuration registers: ADC shift and the two hold thresholds.
// Depends on tbhmc_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module tbhmc_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output tbhmc_pkg::cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_shift         <= 4'd4;
      cfg.combo_hold_ticks  <= 8'd20;
      cfg.single_hold_ticks <= 8'd4;
    end else if (wr_en) begin
      case (paddr[3:2])
        tbhmc_pkg::REG_ADC_SHIFT:   cfg.adc_shift         <= pwdata[3:0];
        tbhmc_pkg::REG_COMBO_HOLD:  cfg.combo_hold_ticks  <= pwdata[7:0];
        tbhmc_pkg::REG_SINGLE_HOLD: cfg.single_hold_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Byte lanes below the word are ignored on both reads and writes.
  always_comb begin
    case (paddr[3:2])
      tbhmc_pkg::REG_ADC_SHIFT:   prdata = {28'd0, cfg.adc_shift};
      tbhmc_pkg::REG_COMBO_HOLD:  prdata = {24'd0, cfg.combo_hold_ticks};
      tbhmc_pkg::REG_SINGLE_HOLD: prdata = {24'd0, cfg.single_hold_ticks};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/tbhmc_step.sv */
// Next-state logic for one item: latch toggles, tick hold counting and the
// power, mode and calibrate decisions. Depends on tbhmc_pkg.
`default_nettype none

module tbhmc_step (
  input  wire tbhmc_pkg::item_t       item,
  input  wire tbhmc_pkg::cfg_t        cfg,
  input  wire tbhmc_pkg::ctrl_state_t cur,
  output tbhmc_pkg::ctrl_state_t      nxt
);

  function automatic logic [11:0] shift_level(input logic [11:0] sample,
                                              input logic [3:0]  sh);
    logic [11:0] res;
    begin
      if (sh >= 4'd12) res = 12'd0;
      else             res = sample >> sh;
      return res;
    end
  endfunction

  logic              power_low;
  logic              mode_low;
  logic [15:0]       ph_inc;
  logic [15:0]       mh_inc;
  logic [16:0]       hold_sum;
  logic [8:0]        mode_plus;

  assign power_low = !item.power_pin_high;
  assign mode_low  = !item.mode_pin_high;
  assign ph_inc    = cur.power_latch ? (cur.power_hold + 16'd1) : 16'd0;
  assign mh_inc    = cur.mode_latch  ? (cur.mode_hold + 16'd1)  : 16'd0;
  assign hold_sum  = {1'b0, ph_inc} + {1'b0, mh_inc};
  assign mode_plus = {1'b0, cur.illum_mode} + 9'd1;

  always_comb begin
    nxt = cur;
    case (item.cmd)
      tbhmc_pkg::CMD_TICK: begin
        nxt.levels[0]  = shift_level(item.adc_red,    cfg.adc_shift);
        nxt.levels[1]  = shift_level(item.adc_green,  cfg.adc_shift);
        nxt.levels[2]  = shift_level(item.adc_blue,   cfg.adc_shift);
        nxt.levels[3]  = shift_level(item.adc_bright, cfg.adc_shift);
        nxt.power_hold = ph_inc;
        nxt.mode_hold  = mh_inc;
        if (cur.power_latch && cur.mode_latch) begin
          // Both buttons held: only the calibrate toggle is considered.
          if (hold_sum > {9'd0, cfg.combo_hold_ticks}) begin
            nxt.power_hold  = 16'd0;
            nxt.mode_hold   = 16'd0;
            nxt.power_latch = 1'b0;
            nxt.mode_latch  = 1'b0;
            if (power_low && mode_low) begin
              nxt.dev_state = (cur.dev_state == tbhmc_pkg::DEV_CALIB) ?
                              tbhmc_pkg::DEV_SLEEP : tbhmc_pkg::DEV_CALIB;
            end
          end
        end else if (cur.dev_state != tbhmc_pkg::DEV_CALIB) begin
          if (mh_inc > {8'd0, cfg.single_hold_ticks}) begin
            nxt.mode_hold  = 16'd0;
            nxt.mode_latch = 1'b0;
            // The index never leaves the range, so one compare wraps it.
            nxt.illum_mode = (mode_plus >= tbhmc_pkg::ILLUM_MODE_COUNT) ?
                             8'd0 : mode_plus[7:0];
          end
          if (ph_inc > {8'd0, cfg.single_hold_ticks}) begin
            nxt.power_hold  = 16'd0;
            nxt.mode_latch  = mode_low;
            nxt.power_latch = 1'b0;
            if (power_low) begin
              nxt.dev_state = (cur.dev_state == tbhmc_pkg::DEV_WORK) ?
                              tbhmc_pkg::DEV_SLEEP : tbhmc_pkg::DEV_WORK;
            end
          end
        end
      end
      tbhmc_pkg::CMD_POWER_EDGE: begin
        if (power_low) nxt.power_latch = !cur.power_latch;
      end
      tbhmc_pkg::CMD_MODE_EDGE: begin
        if (mode_low) nxt.mode_latch = !cur.mode_latch;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/two_button_hold_mode_controller_core.sv */
// Top level of the two-button hold and mode controller: input register,
// controller state, result register and configuration port.
// Depends on tbhmc_pkg, tbhmc_cfg_regs and tbhmc_step.
//
//   channel   handshake                    payload
//   item      item_valid / item_stall      item   (tbhmc_pkg::item_t)
//   result    result_valid / result_stall  result (tbhmc_pkg::result_t)
//   config    psel / penable / pready      paddr, pwdata, prdata
//
// One item per cycle sustained while the result is not stalled; each item passes
// from its transfer through the input register, then the step logic into the
// result register, and is held there until it is taken.
// Reset (rst, synchronous) puts the device in sleep with mode 0, latches,
// hold counts and levels clear, and the registers at their defaults.
// A stalled result holds the result register; the input register then
// fills and item_stall rises until the result is taken.
`default_nettype none

module two_button_hold_mode_controller_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire tbhmc_pkg::item_t   item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output tbhmc_pkg::result_t      result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  tbhmc_pkg::cfg_t        cfg;
  tbhmc_pkg::item_t       in_reg;
  logic                   in_vld;
  logic                   advance;
  tbhmc_pkg::ctrl_state_t st;
  tbhmc_pkg::ctrl_state_t st_next;

  tbhmc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbhmc_step u_step (
    .item (in_reg),
    .cfg  (cfg),
    .cur  (st),
    .nxt  (st_next)
  );

  assign advance    = in_vld && (!result_valid || !result_stall);
  assign item_stall = in_vld && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!item_stall) begin
      in_vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      in_reg <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.dev_state   <= tbhmc_pkg::DEV_SLEEP;
      st.illum_mode  <= 8'd0;
      st.power_hold  <= 16'd0;
      st.mode_hold   <= 16'd0;
      st.power_latch <= 1'b0;
      st.mode_latch  <= 1'b0;
      st.levels      <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.device_state <= st_next.dev_state;
      result.illum_mode   <= st_next.illum_mode;
      result.power_armed  <= st_next.power_latch;
      result.mode_armed   <= st_next.mode_latch;
      result.level_red    <= st_next.levels[0];
      result.level_green  <= st_next.levels[1];
      result.level_blue   <= st_next.levels[2];
      result.level_bright <= st_next.levels[3];
    end
  end

  // The mode index stays below the mode count.
  a_mode_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, st.illum_mode} < tbhmc_pkg::ILLUM_MODE_COUNT)
    else $error("illumination mode index out of range");

  // Device state code 3 is never reached.
  a_state_code: assert property (@(posedge clk) disable iff (rst)
    st.dev_state == tbhmc_pkg::DEV_SLEEP || st.dev_state == tbhmc_pkg::DEV_WORK ||
    st.dev_state == tbhmc_pkg::DEV_CALIB)
    else $error("device state holds an unused code");

  // Stall toward the source only when an item is waiting in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> in_vld)
    else $error("item stall without a held item");

  // An item that leaves the input register shows up as a valid result.
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("advanced item produced no result");

endmodule

`default_nettype wire

/* tb/hold_ctrl_scoreboard.sv */
`timescale 1ns / 1ps
// Scoreboard for the two-button hold and mode controller: a predictor of the
// controller state and the queue of results due. Depends on tbhmc_pkg.
package hold_ctrl_sb_pkg;
  import tbhmc_pkg::*;

  class hold_ctrl_scoreboard;
    cfg_t                    regs;
    logic [1:0]              dev_state;
    logic [7:0]              illum_mode;
    logic [HOLD_W-1:0]       power_hold;
    logic [HOLD_W-1:0]       mode_hold;
    logic                    power_latch;
    logic                    mode_latch;
    logic [3:0][LEVEL_W-1:0] levels;
    result_t                 due_results[$];
    int                      mismatches;

    function new();
      regs.adc_shift         = 4'd4;
      regs.combo_hold_ticks  = 8'd20;
      regs.single_hold_ticks = 8'd4;
      dev_state   = DEV_SLEEP;
      illum_mode  = '0;
      power_hold  = '0;
      mode_hold   = '0;
      power_latch = 1'b0;
      mode_latch  = 1'b0;
      levels      = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_ADC_SHIFT:   regs.adc_shift = value[3:0];
        REG_COMBO_HOLD:  regs.combo_hold_ticks = value[7:0];
        REG_SINGLE_HOLD: regs.single_hold_ticks = value[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_ADC_SHIFT:  return 32'(regs.adc_shift);
        REG_COMBO_HOLD: return 32'(regs.combo_hold_ticks);
        default:        return 32'(regs.single_hold_ticks);
      endcase
    endfunction

    function logic [LEVEL_W-1:0] level_of(logic [LEVEL_W-1:0] sample);
      if (regs.adc_shift >= 4'd12) return '0;
      return sample >> regs.adc_shift;
    endfunction

    function void run_tick(item_t it);
      logic          power_low;
      logic          mode_low;
      logic [HOLD_W:0] hold_sum;
      power_low = !it.power_pin_high;
      mode_low  = !it.mode_pin_high;
      levels[0] = level_of(it.adc_red);
      levels[1] = level_of(it.adc_green);
      levels[2] = level_of(it.adc_blue);
      levels[3] = level_of(it.adc_bright);
      mode_hold  = mode_latch ? mode_hold + 1'b1 : '0;
      power_hold = power_latch ? power_hold + 1'b1 : '0;

      // With both buttons latched only the calibrate toggle can happen.
      if (mode_latch && power_latch) begin
        hold_sum = {1'b0, power_hold} + {1'b0, mode_hold};
        if (hold_sum > (HOLD_W + 1)'(regs.combo_hold_ticks)) begin
          power_hold = '0;
          mode_hold  = '0;
          if (power_low && mode_low)
            dev_state = (dev_state == DEV_CALIB) ? DEV_SLEEP : DEV_CALIB;
          mode_latch  = 1'b0;
          power_latch = 1'b0;
        end
        return;
      end
      if (dev_state == DEV_CALIB) return;

      if (mode_hold > HOLD_W'(regs.single_hold_ticks)) begin
        mode_hold  = '0;
        illum_mode = 8'((int'(illum_mode) + 1) % NUM_ILLUM_MODES);
        mode_latch = 1'b0;
      end
      // A power action reloads the mode latch from its pin.
      if (power_hold > HOLD_W'(regs.single_hold_ticks)) begin
        power_hold = '0;
        mode_latch = mode_low;
        if (power_low)
          dev_state = (dev_state == DEV_WORK) ? DEV_SLEEP : DEV_WORK;
        power_latch = 1'b0;
      end
    endfunction

    function void note_item(item_t it);
      result_t r;
      case (it.cmd)
        CMD_TICK:       run_tick(it);
        CMD_POWER_EDGE: if (!it.power_pin_high) power_latch = !power_latch;
        CMD_MODE_EDGE:  if (!it.mode_pin_high) mode_latch = !mode_latch;
        default: ;
      endcase
      r.device_state = dev_state;
      r.illum_mode   = illum_mode;
      r.power_armed  = power_latch;
      r.mode_armed   = mode_latch;
      r.level_red    = levels[0];
      r.level_green  = levels[1];
      r.level_blue   = levels[2];
      r.level_bright = levels[3];
      due_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("ERROR at %0t: %0s is 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("result with no item pending, device_state", 32'(got.device_state), '0);
        return;
      end
      want = due_results.pop_front();
      if (got.device_state !== want.device_state)
        report("device_state", 32'(got.device_state), 32'(want.device_state));
      if (got.illum_mode !== want.illum_mode)
        report("illum_mode", 32'(got.illum_mode), 32'(want.illum_mode));
      if (got.power_armed !== want.power_armed)
        report("power_armed", 32'(got.power_armed), 32'(want.power_armed));
      if (got.mode_armed !== want.mode_armed)
        report("mode_armed", 32'(got.mode_armed), 32'(want.mode_armed));
      if (got.level_red !== want.level_red)
        report("level_red", 32'(got.level_red), 32'(want.level_red));
      if (got.level_green !== want.level_green)
        report("level_green", 32'(got.level_green), 32'(want.level_green));
      if (got.level_blue !== want.level_blue)
        report("level_blue", 32'(got.level_blue), 32'(want.level_blue));
      if (got.level_bright !== want.level_bright)
        report("level_bright", 32'(got.level_bright), 32'(want.level_bright));
    endtask

    function int pending();
      return due_results.size();
    endfunction
  endclass

endpackage

/* tb/two_button_hold_mode_controller_core_test.sv */
`timescale 1ns / 1ps
// Self-checking test of two_button_hold_mode_controller_core: button gestures,
// ticks and register settings, with random idling on both channels.
// Depends on tbhmc_pkg, hold_ctrl_sb_pkg and the controller RTL.
module two_button_hold_mode_controller_core_test;
  import tbhmc_pkg::*;
  import hold_ctrl_sb_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PRESSURE_CYCLES = 250;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hold_ctrl_scoreboard sb = new();
  int cycles        = 0;
  int items_sent    = 0;
  int sender_calm   = 0;
  int receiver_calm = 0;

  two_button_hold_mode_controller_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short waits, sometimes long ones, and now and then a calm stretch.
  task automatic draw_wait(inout int calm, output int w);
    if (calm > 0) begin
      calm--;
      w = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      w = 0;
    end else if ($urandom_range(0, 2) == 0) begin
      w = $urandom_range(0, 16);
    end else begin
      w = $urandom_range(0, 2);
    end
  endtask

  function automatic item_t mk(logic [1:0] cmd, logic ph, logic mh);
    item_t it;
    it.cmd            = cmd;
    it.power_pin_high = ph;
    it.mode_pin_high  = mh;
    it.adc_red        = 12'($urandom_range(0, 4095));
    it.adc_green      = 12'($urandom_range(0, 4095));
    it.adc_blue       = 12'($urandom_range(0, 4095));
    it.adc_bright     = 12'($urandom_range(0, 4095));
    return it;
  endfunction

  // Number of ticks for a hold; usually just past the threshold.
  function automatic int hold_len(int threshold);
    if ($urandom_range(0, 3) != 0) return threshold + 1 + $urandom_range(0, 2);
    return $urandom_range(0, threshold + 2);
  endfunction

  task automatic send_item(item_t it);
    int w;
    draw_wait(sender_calm, w);
    if (w > 0) begin
      item_valid = 1'b0;
      repeat (w) @(negedge clk);
    end
    item       = it;
    item_valid = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic apb_cycle(logic wr, logic [1:0] idx, logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] mask;
    apb_cycle(1'b1, idx, value, rd);
    sb.write_reg(idx, value);
    apb_cycle(1'b0, idx, '0, rd);
    mask = (idx == REG_ADC_SHIFT) ? 32'hF : 32'hFF;
    if ((rd & mask) !== sb.reg_value(idx))
      sb.report("register readback", rd & mask, sb.reg_value(idx));
  endtask

  // Drop valid and wait until every result due has been taken.
  task automatic settle();
    item_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic play_gesture();
    int   kind;
    int   n;
    logic power_first;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      // Power hold: press, then ticks with the pin mostly held low.
      if (!sb.power_latch || $urandom_range(0, 7) == 0)
        send_item(mk(CMD_POWER_EDGE, 1'b0, 1'($urandom_range(0, 1))));
      n = hold_len(sb.regs.single_hold_ticks);
      repeat (n)
        send_item(mk(CMD_TICK, 1'($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1))));
    end else if (kind <= 5) begin
      if (!sb.mode_latch || $urandom_range(0, 7) == 0)
        send_item(mk(CMD_MODE_EDGE, 1'($urandom_range(0, 1)), 1'b0));
      n = hold_len(sb.regs.single_hold_ticks);
      repeat (n)
        send_item(mk(CMD_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 7) == 0)));
    end else if (kind <= 7) begin
      // Two-button hold toward the calibrate toggle.
      power_first = 1'($urandom_range(0, 1));
      if (power_first && !sb.power_latch) send_item(mk(CMD_POWER_EDGE, 1'b0, 1'b0));
      if (!sb.mode_latch) send_item(mk(CMD_MODE_EDGE, 1'b0, 1'b0));
      if (!power_first && !sb.power_latch) send_item(mk(CMD_POWER_EDGE, 1'b0, 1'b0));
      n = hold_len(sb.regs.combo_hold_ticks / 2);
      repeat (n)
        send_item(mk(CMD_TICK, 1'($urandom_range(0, 9) == 0),
                      1'($urandom_range(0, 9) == 0)));
    end else if (kind == 8) begin
      send_item(mk(2'($urandom_range(1, 2)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1))));
    end else begin
      repeat ($urandom_range(1, 4))
        send_item(mk(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1))));
    end
  endtask

  initial begin : stimulus
    item_t it;
    int    p;
    int    n;
    int    target;
    int    sh;
    int    co;
    int    si;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Short thresholds keep the directed gestures brief.
    set_reg(REG_COMBO_HOLD, 32'd2);
    set_reg(REG_SINGLE_HOLD, 32'd1);

    it = mk(CMD_TICK, 1'b1, 1'b1);
    it.adc_red = '0; it.adc_green = '0; it.adc_blue = '0; it.adc_bright = '0;
    send_item(it);
    it = mk(CMD_TICK, 1'b1, 1'b1);
    it.adc_red = '1; it.adc_green = '1; it.adc_blue = '1; it.adc_bright = '1;
    send_item(it);
    send_item(mk(CMD_UNUSED, 1'b0, 1'b0));
    // Edge events on released pins are ignored.
    send_item(mk(CMD_POWER_EDGE, 1'b1, 1'b0));
    send_item(mk(CMD_MODE_EDGE, 1'b0, 1'b1));
    // Mode hold advances the mode, power hold wakes the device.
    send_item(mk(CMD_MODE_EDGE, 1'b1, 1'b0));
    repeat (2) send_item(mk(CMD_TICK, 1'b1, 1'b0));
    send_item(mk(CMD_POWER_EDGE, 1'b0, 1'b1));
    repeat (2) send_item(mk(CMD_TICK, 1'b0, 1'b1));
    // Both held: into calibrate, a mode hold that must not act, then out again.
    send_item(mk(CMD_POWER_EDGE, 1'b0, 1'b0));
    send_item(mk(CMD_MODE_EDGE, 1'b0, 1'b0));
    repeat (2) send_item(mk(CMD_TICK, 1'b0, 1'b0));
    send_item(mk(CMD_MODE_EDGE, 1'b1, 1'b0));
    repeat (3) send_item(mk(CMD_TICK, 1'b1, 1'b0));
    send_item(mk(CMD_POWER_EDGE, 1'b0, 1'b0));
    send_item(mk(CMD_TICK, 1'b0, 1'b0));
    settle();

    for (p = 0; p < 7; p++) begin
      case (p)
        0: begin sh = 4;  co = 20;  si = 4;   n = 250; end
        1: begin sh = 0;  co = 0;   si = 0;   n = 250; end
        2: begin sh = 11; co = 255; si = 255; n = 200; end
        3: begin
          sh = 12; co = $urandom_range(0, 8); si = $urandom_range(0, 3); n = 250;
        end
        4: begin
          sh = 15; co = $urandom_range(0, 40); si = $urandom_range(0, 12); n = 250;
        end
        default: begin
          sh = $urandom_range(0, 11);
          co = $urandom_range(0, 40);
          si = $urandom_range(0, 12);
          n  = 275;
        end
      endcase
      set_reg(REG_ADC_SHIFT, 32'(sh));
      set_reg(REG_COMBO_HOLD, 32'(co));
      set_reg(REG_SINGLE_HOLD, 32'(si));
      target = items_sent + n;
      while (items_sent < target) play_gesture();
      settle();
    end

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Result side; twice it holds off long enough for the block to back up.
  initial begin : receiver
    int w;
    int taken;
    taken        = 0;
    result_stall = 1'b0;
    forever begin
      if (taken == 300 || taken == 1000) begin
        result_stall = 1'b1;
        repeat (PRESSURE_CYCLES) @(negedge clk);
      end
      draw_wait(receiver_calm, w);
      if (w > 0) begin
        result_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      result_stall = 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
